### rtl/core/hbnp_pkg.sv
// Package for the hash bucket neighbor pruner: payload structs, codes,
// controller states, defaults and the (distance, id) ordering function.
// No dependencies.
package hbnp_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int HASH_WIDTH_DEF  = 16;
    localparam logic [6:0] LIMIT_RESET = 7'd32;

    localparam logic CMD_OFFER  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic KIND_DISP     = 1'b0;
    localparam logic KIND_NEIGHBOR = 1'b1;

    localparam logic [2:0] DISP_ADDED    = 3'd0;
    localparam logic [2:0] DISP_REPLACED = 3'd1;
    localparam logic [2:0] DISP_EVICTED  = 3'd2;
    localparam logic [2:0] DISP_DROPPED  = 3'd3;
    localparam logic [2:0] DISP_SELF     = 3'd4;

    localparam logic REG_LIMIT = 1'b0;

    typedef struct packed {
        logic        command;
        logic [30:0] node_id;
        logic [30:0] candidate_id;
        logic [31:0] squared_distance;
        logic [15:0] hash_code;
    } item_t;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  disposition;
        logic [30:0] neighbor_id;
        logic        neighbor_valid;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SORT,
        ST_EMIT
    } state_t;

    // true when (da, ia) orders strictly ahead of (db, ib)
    function automatic logic orders_before(input logic [31:0] da, input logic [30:0] ia,
                                           input logic [31:0] db, input logic [30:0] ib);
        orders_before = (da < db) || ((da == db) && (ia < ib));
    endfunction

endpackage

### rtl/core/hash_bucket_neighbor_pruner.sv
// Hash bucket neighbor pruner top level: controller, valid bits, APB register.
// Depends on hbnp_pkg and hbnp_ram (entry store: hash, id, distance).
//
// Usage: a command transfer is taken when start is high and busy is low.
// item.command selects offer (one disposition result) or finish (survivors
// in ascending (distance, id) order, then the table is cleared; an empty
// table gives one invalid neighbor result). Each result is shown for one
// cycle with result_strobe; result.last marks the final one of a command.
// The receiver cannot stall the block.
// Offer: self and zero-limit results appear in the cycle after the transfer;
// a regular offer scans the entry RAM one entry per cycle (one read port,
// registered read data), then decides in ST_DECIDE. Finish with n survivors:
// n selection passes, each an ST_SORT scan and one ST_EMIT result. busy is
// high from the transfer until the last result is driven, but stays low for
// self, zero-limit and empty finish commands. The bucket limit is written
// through APB at address 0 (reset 32); the user must write it only while
// idle, the block does not enforce it. Reset clears all valid bits and the
// occupancy count; no clearing pass.
module hash_bucket_neighbor_pruner #(
    parameter int TABLE_DEPTH = hbnp_pkg::TABLE_DEPTH_DEF,
    parameter int HASH_WIDTH  = hbnp_pkg::HASH_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  hbnp_pkg::item_t  item,
    output logic             result_strobe,
    output hbnp_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KW = $clog2(TABLE_DEPTH + 1);
    localparam int HW = (HASH_WIDTH < 16) ? HASH_WIDTH : 16;
    localparam int EW = HW + 63;

    hbnp_pkg::state_t state_reg, state_next;

    logic [KW-1:0]        k_reg, k_next;
    logic [KW-1:0]        occ_reg, occ_next;
    logic [KW-1:0]        left_reg, left_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] taken_reg, taken_next;
    logic [6:0]           maxdeg_reg, maxdeg_next;
    logic [30:0]          cand_reg, cand_next;
    logic [31:0]          dist_reg, dist_next;
    logic [HW-1:0]        hash_reg, hash_next;

    logic                 match_f_reg, match_f_next;
    logic [AW-1:0]        match_idx_reg, match_idx_next;
    logic [31:0]          match_d_reg, match_d_next;
    logic [30:0]          match_id_reg, match_id_next;
    logic                 free_f_reg, free_f_next;
    logic [AW-1:0]        free_idx_reg, free_idx_next;
    logic                 far_f_reg, far_f_next;
    logic [AW-1:0]        far_idx_reg, far_idx_next;
    logic [31:0]          far_d_reg, far_d_next;
    logic [30:0]          far_id_reg, far_id_next;

    logic                 strobe_reg, strobe_next;
    hbnp_pkg::result_t    result_reg, result_next;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [EW-1:0]        wdata;
    logic [AW-1:0]        raddr;
    logic [EW-1:0]        rdata;

    logic [6:0]           lim;
    logic [KW-1:0]        eidx_full;
    logic [AW-1:0]        eidx;
    logic [HW-1:0]        e_hash;
    logic [30:0]          e_id;
    logic [31:0]          e_dist;
    logic                 scan_end;

    hbnp_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign lim       = (maxdeg_reg > 7'(TABLE_DEPTH)) ? 7'(TABLE_DEPTH) : maxdeg_reg;
    assign eidx_full = k_reg - KW'(1);
    assign eidx      = eidx_full[AW-1:0];
    assign e_hash    = rdata[EW-1 -: HW];
    assign e_id      = rdata[62:32];
    assign e_dist    = rdata[31:0];
    assign scan_end  = (k_reg == KW'(TABLE_DEPTH));
    assign raddr     = (k_reg < KW'(TABLE_DEPTH)) ? k_reg[AW-1:0] : '0;

    assign busy          = (state_reg != hbnp_pkg::ST_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = result_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr == {hbnp_pkg::REG_LIMIT, 2'b00}) ? {25'd0, maxdeg_reg}
                                                                   : 32'd0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hbnp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (item.command == hbnp_pkg::CMD_FINISH)
                    begin
                        if (occ_reg != '0)
                        begin
                            state_next = hbnp_pkg::ST_SORT;
                        end
                    end
                    else if ((item.candidate_id != item.node_id) && (lim != 7'd0))
                    begin
                        state_next = hbnp_pkg::ST_SCAN;
                    end
                end
            end
            hbnp_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = hbnp_pkg::ST_DECIDE;
                end
            end
            hbnp_pkg::ST_DECIDE:
            begin
                state_next = hbnp_pkg::ST_IDLE;
            end
            hbnp_pkg::ST_SORT:
            begin
                if (scan_end)
                begin
                    state_next = hbnp_pkg::ST_EMIT;
                end
            end
            hbnp_pkg::ST_EMIT:
            begin
                state_next = (left_reg == KW'(1)) ? hbnp_pkg::ST_IDLE : hbnp_pkg::ST_SORT;
            end
            default:
            begin
                state_next = hbnp_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        k_next         = k_reg;
        occ_next       = occ_reg;
        left_next      = left_reg;
        valid_next     = valid_reg;
        taken_next     = taken_reg;
        maxdeg_next    = maxdeg_reg;
        cand_next      = cand_reg;
        dist_next      = dist_reg;
        hash_next      = hash_reg;
        match_f_next   = match_f_reg;
        match_idx_next = match_idx_reg;
        match_d_next   = match_d_reg;
        match_id_next  = match_id_reg;
        free_f_next    = free_f_reg;
        free_idx_next  = free_idx_reg;
        far_f_next     = far_f_reg;
        far_idx_next   = far_idx_reg;
        far_d_next     = far_d_reg;
        far_id_next    = far_id_reg;
        strobe_next    = 1'b0;
        result_next    = result_reg;
        we             = 1'b0;
        waddr          = match_idx_reg;
        wdata          = {hash_reg, cand_reg, dist_reg};

        if (psel && penable && pwrite && (paddr == {hbnp_pkg::REG_LIMIT, 2'b00}))
        begin
            maxdeg_next = pwdata[6:0];
        end

        case (state_reg)
            hbnp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cand_next    = item.candidate_id;
                    dist_next    = item.squared_distance;
                    hash_next    = item.hash_code[HW-1:0];
                    k_next       = '0;
                    match_f_next = 1'b0;
                    free_f_next  = 1'b0;
                    far_f_next   = 1'b0;
                    taken_next   = '0;
                    left_next    = occ_reg;
                    result_next.neighbor_id    = '0;
                    result_next.neighbor_valid = 1'b0;
                    result_next.last           = 1'b1;
                    if (item.command == hbnp_pkg::CMD_FINISH)
                    begin
                        if (occ_reg == '0)
                        begin
                            strobe_next             = 1'b1;
                            result_next.result_kind = hbnp_pkg::KIND_NEIGHBOR;
                            result_next.disposition = hbnp_pkg::DISP_ADDED;
                        end
                    end
                    else if (item.candidate_id == item.node_id)
                    begin
                        strobe_next             = 1'b1;
                        result_next.result_kind = hbnp_pkg::KIND_DISP;
                        result_next.disposition = hbnp_pkg::DISP_SELF;
                    end
                    else if (lim == 7'd0)
                    begin
                        strobe_next             = 1'b1;
                        result_next.result_kind = hbnp_pkg::KIND_DISP;
                        result_next.disposition = hbnp_pkg::DISP_DROPPED;
                    end
                end
            end
            hbnp_pkg::ST_SCAN:
            begin
                k_next = k_reg + KW'(1);
                if (k_reg != '0)
                begin
                    if (!valid_reg[eidx])
                    begin
                        if (!free_f_reg)
                        begin
                            free_f_next   = 1'b1;
                            free_idx_next = eidx;
                        end
                    end
                    else
                    begin
                        if (!match_f_reg && (e_hash == hash_reg))
                        begin
                            match_f_next   = 1'b1;
                            match_idx_next = eidx;
                            match_d_next   = e_dist;
                            match_id_next  = e_id;
                        end
                        if (!far_f_reg ||
                            hbnp_pkg::orders_before(far_d_reg, far_id_reg, e_dist, e_id))
                        begin
                            far_f_next   = 1'b1;
                            far_idx_next = eidx;
                            far_d_next   = e_dist;
                            far_id_next  = e_id;
                        end
                    end
                end
            end
            hbnp_pkg::ST_DECIDE:
            begin
                strobe_next                = 1'b1;
                result_next.result_kind    = hbnp_pkg::KIND_DISP;
                result_next.neighbor_id    = '0;
                result_next.neighbor_valid = 1'b0;
                result_next.last           = 1'b1;
                result_next.disposition    = hbnp_pkg::DISP_DROPPED;
                if (match_f_reg)
                begin
                    if (hbnp_pkg::orders_before(dist_reg, cand_reg, match_d_reg, match_id_reg))
                    begin
                        we                      = 1'b1;
                        waddr                   = match_idx_reg;
                        result_next.disposition = hbnp_pkg::DISP_REPLACED;
                    end
                end
                else if ((7'(occ_reg) < lim) && free_f_reg)
                begin
                    we                      = 1'b1;
                    waddr                   = free_idx_reg;
                    valid_next[free_idx_reg] = 1'b1;
                    occ_next                = occ_reg + KW'(1);
                    result_next.disposition = hbnp_pkg::DISP_ADDED;
                end
                else if (far_f_reg &&
                         hbnp_pkg::orders_before(dist_reg, cand_reg, far_d_reg, far_id_reg))
                begin
                    we                      = 1'b1;
                    waddr                   = far_idx_reg;
                    result_next.disposition = hbnp_pkg::DISP_EVICTED;
                end
            end
            hbnp_pkg::ST_SORT:
            begin
                k_next = k_reg + KW'(1);
                if ((k_reg != '0) && valid_reg[eidx] && !taken_reg[eidx])
                begin
                    if (!far_f_reg ||
                        hbnp_pkg::orders_before(e_dist, e_id, far_d_reg, far_id_reg))
                    begin
                        far_f_next   = 1'b1;
                        far_idx_next = eidx;
                        far_d_next   = e_dist;
                        far_id_next  = e_id;
                    end
                end
            end
            hbnp_pkg::ST_EMIT:
            begin
                strobe_next                = 1'b1;
                result_next.result_kind    = hbnp_pkg::KIND_NEIGHBOR;
                result_next.disposition    = hbnp_pkg::DISP_ADDED;
                result_next.neighbor_id    = far_id_reg;
                result_next.neighbor_valid = 1'b1;
                result_next.last           = (left_reg == KW'(1));
                taken_next[far_idx_reg]    = 1'b1;
                left_next                  = left_reg - KW'(1);
                k_next                     = '0;
                far_f_next                 = 1'b0;
                if (left_reg == KW'(1))
                begin
                    valid_next = '0;
                    occ_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hbnp_pkg::ST_IDLE;
            k_reg       <= '0;
            occ_reg     <= '0;
            left_reg    <= '0;
            valid_reg   <= '0;
            taken_reg   <= '0;
            maxdeg_reg  <= hbnp_pkg::LIMIT_RESET;
            match_f_reg <= 1'b0;
            free_f_reg  <= 1'b0;
            far_f_reg   <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            occ_reg     <= occ_next;
            left_reg    <= left_next;
            valid_reg   <= valid_next;
            taken_reg   <= taken_next;
            maxdeg_reg  <= maxdeg_next;
            match_f_reg <= match_f_next;
            free_f_reg  <= free_f_next;
            far_f_reg   <= far_f_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg      <= cand_next;
        dist_reg      <= dist_next;
        hash_reg      <= hash_next;
        match_idx_reg <= match_idx_next;
        match_d_reg   <= match_d_next;
        match_id_reg  <= match_id_next;
        free_idx_reg  <= free_idx_next;
        far_idx_reg   <= far_idx_next;
        far_d_reg     <= far_d_next;
        far_id_reg    <= far_id_next;
        result_reg    <= result_next;
    end

endmodule

### rtl/core/hbnp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hbnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### tb/hash_bucket_neighbor_pruner_test.sv
// Testbench for hash_bucket_neighbor_pruner: command transfers, APB limit writes,
// and a scoreboard that models the bucket table and checks every result.
// Depends on hbnp_pkg and the pruner RTL.
`timescale 1ns / 100ps

module hash_bucket_neighbor_pruner_test;

    localparam int SLOTS = hbnp_pkg::TABLE_DEPTH_DEF;

    class prune_scoreboard;
        logic [6:0]  limit_value;
        logic        valid_q[SLOTS];
        logic [15:0] hash_q[SLOTS];
        logic [30:0] id_q[SLOTS];
        logic [31:0] dist_q[SLOTS];
        int          occupied;
        hbnp_pkg::result_t pending[$];
        int          mismatches;
        int          checked;
        int          disp_seen[5];
        int          neighbors_seen;

        function void clear_table();
            foreach (valid_q[i])
                valid_q[i] = 1'b0;
            occupied = 0;
        endfunction

        function logic [2:0] place(hbnp_pkg::item_t it);
            int limit, match, free_slot, far;
            match = -1;
            free_slot = -1;
            far = -1;
            limit = (limit_value > SLOTS) ? SLOTS : limit_value;
            if (it.candidate_id == it.node_id)
                return hbnp_pkg::DISP_SELF;
            if (limit == 0)
                return hbnp_pkg::DISP_DROPPED;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!valid_q[i])
                begin
                    if (free_slot < 0)
                        free_slot = i;
                    continue;
                end
                if (match < 0 && hash_q[i] == it.hash_code)
                    match = i;
                if (far < 0 || hbnp_pkg::orders_before(dist_q[far], id_q[far],
                                                       dist_q[i], id_q[i]))
                    far = i;
            end
            if (match >= 0)
            begin
                if (hbnp_pkg::orders_before(it.squared_distance, it.candidate_id,
                                            dist_q[match], id_q[match]))
                begin
                    id_q[match] = it.candidate_id;
                    dist_q[match] = it.squared_distance;
                    return hbnp_pkg::DISP_REPLACED;
                end
                return hbnp_pkg::DISP_DROPPED;
            end
            if (occupied < limit && free_slot >= 0)
            begin
                valid_q[free_slot] = 1'b1;
                hash_q[free_slot] = it.hash_code;
                id_q[free_slot] = it.candidate_id;
                dist_q[free_slot] = it.squared_distance;
                occupied++;
                return hbnp_pkg::DISP_ADDED;
            end
            if (far >= 0 && hbnp_pkg::orders_before(it.squared_distance, it.candidate_id,
                                                    dist_q[far], id_q[far]))
            begin
                hash_q[far] = it.hash_code;
                id_q[far] = it.candidate_id;
                dist_q[far] = it.squared_distance;
                return hbnp_pkg::DISP_EVICTED;
            end
            return hbnp_pkg::DISP_DROPPED;
        endfunction

        function void note_transfer(hbnp_pkg::item_t it);
            hbnp_pkg::result_t r;
            logic taken[SLOTS];
            int left, best;
            r = '0;
            if (it.command == hbnp_pkg::CMD_OFFER)
            begin
                r.result_kind = hbnp_pkg::KIND_DISP;
                r.disposition = place(it);
                r.last = 1'b1;
                pending.insert(pending.size(), r);
                return;
            end
            left = 0;
            foreach (valid_q[i])
            begin
                taken[i] = 1'b0;
                if (valid_q[i])
                    left++;
            end
            r.result_kind = hbnp_pkg::KIND_NEIGHBOR;
            if (left == 0)
            begin
                r.last = 1'b1;
                pending.insert(pending.size(), r);
                return;
            end
            while (left > 0)
            begin
                best = -1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!valid_q[i] || taken[i])
                        continue;
                    if (best < 0 || hbnp_pkg::orders_before(dist_q[i], id_q[i],
                                                            dist_q[best], id_q[best]))
                        best = i;
                end
                taken[best] = 1'b1;
                left--;
                r.neighbor_id = id_q[best];
                r.neighbor_valid = 1'b1;
                r.last = (left == 0);
                pending.insert(pending.size(), r);
            end
            clear_table();
        endfunction

        function void check_result(hbnp_pkg::result_t got);
            hbnp_pkg::result_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected kind %0d disp %0d id %0d valid %0d last %0d",
                        want.result_kind, want.disposition, want.neighbor_id,
                        want.neighbor_valid, want.last);
                    $display("          actual   kind %0d disp %0d id %0d valid %0d last %0d",
                        got.result_kind, got.disposition, got.neighbor_id,
                        got.neighbor_valid, got.last);
                end
            end
            else if (got.result_kind == hbnp_pkg::KIND_DISP)
                disp_seen[got.disposition]++;
            else if (got.neighbor_valid)
                neighbors_seen++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    hbnp_pkg::item_t   item;
    logic        result_strobe;
    hbnp_pkg::result_t result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    prune_scoreboard table_sb;
    int          idle_pct;
    logic [30:0] node;

    hash_bucket_neighbor_pruner DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_strobe(result_strobe), .result(result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        if (rst_n && result_strobe)
            table_sb.check_result(result);

    initial
    begin
        #200ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic hbnp_pkg::item_t rand_item();
        hbnp_pkg::item_t it;
        it.command = 1'($urandom);
        it.node_id = 31'($urandom);
        it.candidate_id = 31'($urandom);
        it.squared_distance = $urandom;
        it.hash_code = 16'($urandom);
        return it;
    endfunction

    task automatic write_limit(input logic [6:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {hbnp_pkg::REG_LIMIT, 2'b00};
        pwdata <= {25'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        table_sb.limit_value = value;
    endtask

    task automatic send(input hbnp_pkg::item_t it);
        while ($urandom_range(99, 0) < idle_pct)
            @(posedge clk);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        table_sb.note_transfer(it);
        start <= 1'b0;
        item <= rand_item();
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic offer(input logic [30:0] cand, input logic [31:0] sq_dist,
                         input logic [15:0] hash);
        hbnp_pkg::item_t it;
        it.command = hbnp_pkg::CMD_OFFER;
        it.node_id = node;
        it.candidate_id = cand;
        it.squared_distance = sq_dist;
        it.hash_code = hash;
        send(it);
    endtask

    task automatic finish_node();
        hbnp_pkg::item_t it;
        it = rand_item();
        it.command = hbnp_pkg::CMD_FINISH;
        send(it);
    endtask

    task automatic settle();
        while (table_sb.pending.size() != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    task automatic random_node(input int count, input int hash_span);
        int pick;
        node = 31'($urandom);
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(19, 0);
            if (pick == 0)
                offer(node, $urandom, 16'($urandom));
            else if (pick < 3)
                offer(31'($urandom), $urandom, 16'($urandom));
            else
                offer(31'($urandom_range(40, 0) | ($urandom_range(1, 0) << 30)),
                      $urandom_range(1, 0) ? $urandom_range(30, 0) : $urandom,
                      16'($urandom_range(hash_span, 0) |
                          (($urandom_range(7, 0) == 0) << 15)));
        end
        finish_node();
    endtask

    initial
    begin
        table_sb = new();
        table_sb.limit_value = hbnp_pkg::LIMIT_RESET;
        table_sb.clear_table();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 36;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty finish, self, add, replace, ties, eviction, extremes
        node = 31'h7FFF_FFFF;
        finish_node();
        offer(31'h7FFF_FFFF, 32'd5, 16'd1);
        offer(31'd10, 32'd100, 16'd1);
        offer(31'd9, 32'd100, 16'd1);
        offer(31'd20, 32'd100, 16'd1);
        offer(31'd0, 32'hFFFF_FFFF, 16'hFFFF);
        offer(31'h7FFF_FFFE, 32'd0, 16'h0000);
        finish_node();
        settle();
        write_limit(7'd2);
        node = 31'd0;
        offer(31'd0, 32'd1, 16'd3);
        offer(31'd5, 32'd50, 16'd1);
        offer(31'd6, 32'd50, 16'd2);
        offer(31'd4, 32'd50, 16'd3);
        offer(31'd7, 32'd60, 16'd4);
        offer(31'd3, 32'd10, 16'd5);
        settle();
        write_limit(7'd0);
        offer(31'd8, 32'd1, 16'd6);
        finish_node();
        settle();
        write_limit(7'd127);
        random_node(20, 80);
        settle();
        write_limit(7'd64);
        random_node(30, 200);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 36 : (phase == 1) ? 84 : 0;
            settle();
            write_limit(phase == 2 ? 7'd1 : 7'($urandom_range(8, 1)));
            for (int n = 0; n < 3; n++)
                random_node($urandom_range(8, 2), 10);
        end
        settle();
        write_limit(7'd3);
        random_node(6, 5);

        settle();
        $display("checked %0d results: added %0d replaced %0d evicted %0d dropped %0d self %0d",
            table_sb.checked, table_sb.disp_seen[hbnp_pkg::DISP_ADDED],
            table_sb.disp_seen[hbnp_pkg::DISP_REPLACED],
            table_sb.disp_seen[hbnp_pkg::DISP_EVICTED],
            table_sb.disp_seen[hbnp_pkg::DISP_DROPPED],
            table_sb.disp_seen[hbnp_pkg::DISP_SELF]);
        $display("survivors emitted %0d, mismatches %0d",
            table_sb.neighbors_seen, table_sb.mismatches);
        if (table_sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### filelist.f
rtl/core/hbnp_pkg.sv
rtl/core/hbnp_ram.sv
rtl/core/hash_bucket_neighbor_pruner.sv
tb/hash_bucket_neighbor_pruner_test.sv
